// ===== hw/rtl/swq_pkg.sv =====
// Package for the sleep/wake queue: entry type, FSM states, sizing constants.
// No dependencies; every other file of the block depends on it.
package swq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned MAX_RESULTS     = 16;
  localparam int unsigned TIME_W          = 48;
  localparam int unsigned ID_W            = 6;
  localparam int unsigned PRIO_W          = 6;

  typedef logic [TIME_W-1:0] time_t;
  typedef logic [ID_W-1:0]   id_t;
  typedef logic [PRIO_W-1:0] prio_t;

  typedef struct packed {
    time_t wtime;
    id_t   id;
    prio_t prio;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_TICK_RD,
    ST_TICK_CMP,
    ST_FIN
  } state_t;

  localparam logic MODE_SLEEP = 1'b0;
  localparam logic MODE_TICK  = 1'b1;

  // true when the new entry must sit in front of entry e
  function automatic logic goes_before(entry_t n, entry_t e);
    goes_before = (n.wtime < e.wtime) || ((n.wtime == e.wtime) && (n.prio > e.prio));
  endfunction

endpackage

// ===== hw/rtl/swq_if.sv =====
// Channel interfaces of the sleep/wake queue: request beat and result beat.
// Depends on swq_pkg.
interface swq_in_if;
  logic                 valid;
  logic                 ready;
  logic                 mode;
  swq_pkg::id_t         task_id;
  swq_pkg::time_t       wake_time;
  swq_pkg::prio_t       task_priority;
  swq_pkg::time_t       current_time;
  modport source (output valid, mode, task_id, wake_time, task_priority, current_time,
                  input ready);
  modport sink   (input valid, mode, task_id, wake_time, task_priority, current_time,
                  output ready);
endinterface

interface swq_out_if;
  logic         valid;
  logic         ready;
  logic         woke;
  swq_pkg::id_t woken_id;
  logic         queue_full;
  logic         last;
  modport source (output valid, woke, woken_id, queue_full, last, input ready);
  modport sink   (input valid, woke, woken_id, queue_full, last, output ready);
endinterface

// ===== hw/rtl/swq_store.sv =====
// Entry memory of the sleep/wake queue: one write port, one read port,
// registered read data. Depends on swq_pkg.
module swq_store #(
  parameter int unsigned QUEUE_DEPTH = swq_pkg::QUEUE_DEPTH_DEF,
  localparam int unsigned AW = $clog2(QUEUE_DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  swq_pkg::entry_t  wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output swq_pkg::entry_t  rdata
);
  import swq_pkg::*;

  entry_t mem [QUEUE_DEPTH];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/swq_ctrl.sv =====
// Sequencer of the sleep/wake queue: ring pointers, insertion walk, wake pops,
// result register. Depends on swq_pkg, swq_if and drives swq_store.
module swq_ctrl #(
  parameter int unsigned QUEUE_DEPTH = swq_pkg::QUEUE_DEPTH_DEF,
  localparam int unsigned AW = $clog2(QUEUE_DEPTH),
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  swq_in_if.sink          in_ch,
  swq_out_if.source       out_ch,
  output logic            mem_we,
  output logic [AW-1:0]   mem_waddr,
  output swq_pkg::entry_t mem_wdata,
  output logic            mem_re,
  output logic [AW-1:0]   mem_raddr,
  input  swq_pkg::entry_t mem_rdata
);
  import swq_pkg::*;

  localparam int unsigned NW = $clog2(MAX_RESULTS + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
  localparam logic [NW-1:0] MAXR_C  = NW'(MAX_RESULTS);

  state_t        state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [NW-1:0] n_r, n_nxt;
  entry_t        new_r;
  time_t         now_r;
  logic          pend_valid_r, pend_valid_nxt;
  id_t           pend_id_r, pend_id_nxt;
  logic          full_r, full_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_woke_r, out_woke_nxt;
  id_t           out_id_r, out_id_nxt;
  logic          out_full_r, out_full_nxt;
  logic          out_last_r, out_last_nxt;

  logic          accept, out_free, due, ahead;
  logic [AW-1:0] phys_j, phys_jm1, phys_1;

  // logical slot to ring address: one add and one conditional subtract
  function automatic logic [AW-1:0] phys(logic [AW-1:0] head, logic [CW-1:0] k);
    logic [CW:0] sum;
    sum = (CW+1)'(head) + (CW+1)'(k);
    if (sum >= (CW+1)'(QUEUE_DEPTH)) begin
      sum = sum - (CW+1)'(QUEUE_DEPTH);
    end
    phys = sum[AW-1:0];
  endfunction

  assign accept    = in_ch.valid && in_ch.ready;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign due       = now_r >= mem_rdata.wtime;
  assign ahead     = goes_before(new_r, mem_rdata);
  assign phys_j    = phys(head_r, j_r);
  assign phys_jm1  = phys(head_r, j_r - CW'(1));
  assign phys_1    = phys(head_r, CW'(1));

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.woke       = out_woke_r;
  assign out_ch.woken_id   = out_id_r;
  assign out_ch.queue_full = out_full_r;
  assign out_ch.last       = out_last_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_ch.mode == MODE_TICK) begin
            state_nxt = ST_TICK_RD;
          end else if (count_r == DEPTH_C) begin
            state_nxt = ST_FIN;
          end else begin
            state_nxt = ST_INS_RD;
          end
        end
      end
      ST_INS_RD:   state_nxt = (j_r == '0) ? ST_FIN : ST_INS_CMP;
      ST_INS_CMP:  state_nxt = ahead ? ST_INS_RD : ST_FIN;
      ST_TICK_RD:  state_nxt = (count_r == '0 || n_r == MAXR_C) ? ST_FIN : ST_TICK_CMP;
      ST_TICK_CMP: begin
        if (!due) begin
          state_nxt = ST_FIN;
        end else if (!pend_valid_r || out_free) begin
          state_nxt = ST_TICK_RD;
        end
      end
      ST_FIN:      state_nxt = out_free ? ST_IDLE : ST_FIN;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    head_nxt       = head_r;
    count_nxt      = count_r;
    j_nxt          = j_r;
    n_nxt          = n_r;
    pend_valid_nxt = pend_valid_r;
    pend_id_nxt    = pend_id_r;
    full_nxt       = full_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_woke_nxt   = out_woke_r;
    out_id_nxt     = out_id_r;
    out_full_nxt   = out_full_r;
    out_last_nxt   = out_last_r;
    mem_we         = 1'b0;
    mem_waddr      = phys_j;
    mem_wdata      = new_r;
    mem_re         = 1'b0;
    mem_raddr      = phys_jm1;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          j_nxt          = count_r;
          n_nxt          = '0;
          pend_valid_nxt = 1'b0;
          full_nxt       = (in_ch.mode == MODE_SLEEP) && (count_r == DEPTH_C);
        end
      end
      ST_INS_RD: begin
        if (j_r == '0) begin
          mem_we    = 1'b1;
          count_nxt = count_r + CW'(1);
        end else begin
          mem_re = 1'b1;
        end
      end
      ST_INS_CMP: begin
        mem_we = 1'b1;
        if (ahead) begin
          // shift the older entry one slot toward the tail
          mem_wdata = mem_rdata;
          j_nxt     = j_r - CW'(1);
        end else begin
          count_nxt = count_r + CW'(1);
        end
      end
      ST_TICK_RD: begin
        mem_raddr = head_r;
        mem_re    = !(count_r == '0 || n_r == MAXR_C);
      end
      ST_TICK_CMP: begin
        if (due && (!pend_valid_r || out_free)) begin
          if (pend_valid_r) begin
            out_valid_nxt = 1'b1;
            out_woke_nxt  = 1'b1;
            out_id_nxt    = pend_id_r;
            out_full_nxt  = 1'b0;
            out_last_nxt  = 1'b0;
          end
          pend_valid_nxt = 1'b1;
          pend_id_nxt    = mem_rdata.id;
          head_nxt       = phys_1;
          count_nxt      = count_r - CW'(1);
          n_nxt          = n_r + NW'(1);
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_woke_nxt  = pend_valid_r;
          out_id_nxt    = pend_valid_r ? pend_id_r : '0;
          out_full_nxt  = full_r;
          out_last_nxt  = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      head_r       <= '0;
      count_r      <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      count_r      <= count_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    j_r        <= j_nxt;
    n_r        <= n_nxt;
    pend_id_r  <= pend_id_nxt;
    full_r     <= full_nxt;
    out_woke_r <= out_woke_nxt;
    out_id_r   <= out_id_nxt;
    out_full_r <= out_full_nxt;
    out_last_r <= out_last_nxt;
    if (accept) begin
      new_r.wtime <= in_ch.wake_time;
      new_r.id    <= in_ch.task_id;
      new_r.prio  <= in_ch.task_priority;
      now_r       <= in_ch.current_time;
    end
  end

endmodule

// ===== hw/rtl/sleep_wake_queue_top.sv =====
// Sorted wake-up queue for sleeping tasks.
// in_ch carries one beat per request: mode 0 inserts (task_id, wake_time,
// task_priority), mode 1 is a timer tick carrying current_time.
// out_ch returns result beats; the final beat of each request has last = 1.
// A sleep request gives one beat (queue_full = 1 when dropped on a full queue).
// A tick gives one beat per woken task in queue order, at most 16, or one
// empty beat when nothing is due.
// Entries live in a ring buffer memory with a registered read. An insert walks
// from the tail, reading and then writing back each entry it moves; a dropped
// insert answers without touching the memory. A tick reads and compares the
// head entry for each woken task and waits while out_ch stalls. The next
// request can be taken in the cycle after the final beat loads. The memory
// read-compare-write loop bounds how fast entries move.
// One request is in flight at a time; in_ch.ready is high only when idle,
// while the last result beat may still wait in the output register.
// A stalled receiver holds the current beat and pauses the wake walk.
// Synchronous reset empties the queue; memory contents need no clearing.
// Depends on swq_pkg, swq_if, swq_store and swq_ctrl.
module sleep_wake_queue_top #(
  parameter int unsigned QUEUE_DEPTH = swq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  swq_in_if.sink    in_ch,
  swq_out_if.source out_ch
);
  import swq_pkg::*;

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  entry_t        mem_wdata, mem_rdata;

  swq_ctrl #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  swq_store #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

// ===== dv/tb_sleep_wake_queue_checker.sv =====
// Scoreboard for the sleep/wake queue: watches request and result beats,
// keeps a sorted copy of the queue and compares every result beat.
// Depends on swq_pkg and swq_if.
`timescale 1ns / 1ps
module tb_sleep_wake_queue_checker #(
  parameter int unsigned DEPTH = swq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  swq_in_if           in_mon,
  swq_out_if          out_mon,
  output int unsigned fail_count,
  output int unsigned pending_beats
);
  import swq_pkg::*;

  typedef struct packed {
    logic woke;
    id_t  woken_id;
    logic queue_full;
    logic last;
  } wake_beat_t;

  entry_t     sleepers[$];
  wake_beat_t wake_expect[$];

  assign pending_beats = wake_expect.size();

  function automatic wake_beat_t mk_beat(logic w, id_t id, logic f, logic l);
    wake_beat_t b;
    b.woke = w; b.woken_id = id; b.queue_full = f; b.last = l;
    return b;
  endfunction

  task automatic predict_request();
    entry_t e;
    int     pos;
    int     n;
    if (in_mon.mode == MODE_SLEEP) begin
      if (sleepers.size() >= DEPTH) begin
        wake_expect.push_back(mk_beat(1'b0, '0, 1'b1, 1'b1));
      end else begin
        e.wtime = in_mon.wake_time; e.id = in_mon.task_id; e.prio = in_mon.task_priority;
        pos = 0;
        // behind every entry it does not beat, so full ties stay in order
        while (pos < sleepers.size() && !(e.wtime < sleepers[pos].wtime ||
               (e.wtime == sleepers[pos].wtime && e.prio > sleepers[pos].prio)))
          pos++;
        sleepers.insert(pos, e);
        wake_expect.push_back(mk_beat(1'b0, '0, 1'b0, 1'b1));
      end
    end else begin
      n = 0;
      while (n < MAX_RESULTS && sleepers.size() > 0 &&
             in_mon.current_time >= sleepers[0].wtime) begin
        wake_expect.push_back(mk_beat(1'b1, sleepers[0].id, 1'b0, 1'b0));
        void'(sleepers.pop_front());
        n++;
      end
      if (n == 0) wake_expect.push_back(mk_beat(1'b0, '0, 1'b0, 1'b1));
      else wake_expect[$].last = 1'b1;
    end
  endtask

  task automatic check_result();
    wake_beat_t exp_b;
    wake_beat_t got;
    got = mk_beat(out_mon.woke, out_mon.woken_id, out_mon.queue_full, out_mon.last);
    if (wake_expect.size() == 0) begin
      fail_count++;
      if (fail_count <= 10) $display("unexpected result beat %p", got);
    end else begin
      exp_b = wake_expect.pop_front();
      if (got !== exp_b) begin
        fail_count++;
        if (fail_count <= 10) $display("result mismatch: expected %p got %p", exp_b, got);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      fail_count = 0;
      sleepers.delete();
      wake_expect.delete();
    end else begin
      // results first: a request accepted now cannot answer in the same edge
      if (out_mon.valid && out_mon.ready) check_result();
      if (in_mon.valid && in_mon.ready) predict_request();
    end
  end
endmodule

// ===== dv/tb_sleep_wake_queue_top.sv =====
// Top of the sleep/wake queue testbench: clock, reset, request stimulus,
// result back-pressure and verdict. Depends on swq_pkg, swq_if, the block
// and tb_sleep_wake_queue_checker.
`timescale 1ns / 1ps
module tb_sleep_wake_queue_top;
  import swq_pkg::*;

  localparam int unsigned RANDOM_REQS = 390;
  localparam int unsigned HANG_LIMIT  = 4000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  int unsigned fail_count;
  int unsigned pending_beats;
  int unsigned idle_cycles = 0;
  bit          quiet_phase = 1'b0;
  time_t       now_tick = '0;

  swq_in_if  req_ch();
  swq_out_if res_ch();

  sleep_wake_queue_top dut (.clk(clk), .rst_n(rst_n), .in_ch(req_ch), .out_ch(res_ch));

  tb_sleep_wake_queue_checker checker_i (
    .clk(clk), .rst_n(rst_n), .in_mon(req_ch), .out_mon(res_ch),
    .fail_count(fail_count), .pending_beats(pending_beats));

  always #4 clk = ~clk;

  initial begin
    req_ch.valid = 1'b0; req_ch.mode = MODE_SLEEP; req_ch.task_id = '0;
    req_ch.wake_time = '0; req_ch.task_priority = '0; req_ch.current_time = '0;
    res_ch.ready = 1'b0;
  end

  // receiver stall bursts
  initial begin
    int n;
    @(posedge clk iff rst_n);
    forever begin
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
        res_ch.ready <= 1'b0;
        n = $urandom_range(1, 11);
        repeat (n) @(posedge clk);
      end else begin
        res_ch.ready <= 1'b1;
        n = $urandom_range(1, 20);
        repeat (n) @(posedge clk);
      end
    end
  end

  // watchdog on cycles with no beat accepted
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (rst_n && idle_cycles >= HANG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_req(logic m, id_t id, time_t wt, prio_t pr, time_t ct);
    int gap;
    if (!quiet_phase && $urandom_range(0, 4) == 0) begin
      req_ch.valid <= 1'b0;
      gap = $urandom_range(1, 11);
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1; req_ch.mode <= m; req_ch.task_id <= id;
    req_ch.wake_time <= wt; req_ch.task_priority <= pr; req_ch.current_time <= ct;
    // hold the beat until the edge that takes it
    @(posedge clk iff req_ch.ready);
  endtask

  task automatic sleep_req(id_t id, time_t wt, prio_t pr);
    send_req(MODE_SLEEP, id, wt, pr, time_t'({$urandom, $urandom}));
  endtask

  task automatic tick_req(time_t ct);
    send_req(MODE_TICK, id_t'($urandom), time_t'({$urandom, $urandom}),
             prio_t'($urandom), ct);
  endtask

  function automatic time_t rand_time();
    return time_t'({$urandom, $urandom});
  endfunction

  initial begin
    int    i;
    time_t t;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty tick, ties, extremes, overflow, wake burst at the result limit
    tick_req('1);
    sleep_req(6'd1, 48'd100, 6'd5);
    sleep_req(6'd2, 48'd100, 6'd5);
    sleep_req(6'd3, 48'd100, 6'd63);
    sleep_req(6'd63, '0, '0);
    sleep_req(6'd0, '1, 6'd63);
    tick_req(48'd99);
    tick_req(48'd100);
    tick_req('1);
    for (i = 0; i < 17; i++) sleep_req(id_t'(i + 20), 48'd7, prio_t'(i));
    tick_req(48'd7);
    tick_req(48'd7);

    // random: short-horizon wake times around a moving clock
    for (i = 0; i < RANDOM_REQS; i++) begin
      if (i > RANDOM_REQS - 60) quiet_phase = 1'b1;
      case ($urandom_range(0, 9))
        0: sleep_req(id_t'($urandom), rand_time(), prio_t'($urandom));
        1: tick_req(rand_time());
        2, 3, 4, 5: begin
          t = now_tick + time_t'($urandom_range(0, 40));
          sleep_req(id_t'($urandom), t, prio_t'($urandom_range(0, 3) == 0 ? 6'd9 : $urandom));
        end
        default: begin
          now_tick = now_tick + time_t'($urandom_range(0, 25));
          tick_req(now_tick);
        end
      endcase
    end
    tick_req('1);
    req_ch.valid <= 1'b0;

    while (pending_beats != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
